>>> rtl/wicc_pkg.sv
// shared types, constants and helpers of the word index code codec
package wicc_pkg;

    // field widths
    localparam int INDEX_W    = 18;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 2;
    localparam int Q_W        = 10;
    localparam int SHORT_IDX_W = 13;
    localparam int LO_W       = 16;

    // code arithmetic
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = 18'd195075;
    localparam logic [INDEX_W-1:0] SHORT_LIMIT = 18'd4080;
    localparam logic [Q_W-1:0]     RADIX_Q     = 10'd255;
    localparam logic [Q_W-1:0]     RADIX_Q2    = 10'd510;
    localparam logic [8:0]         RADIX_REM   = 9'd255;
    localparam logic [BYTE_W-1:0]  SHORT_LEAD  = 8'h80;
    localparam logic [BYTE_W-1:0]  SHORT_LEAD_MAX = 8'hBC;
    localparam logic [BYTE_W-1:0]  LONG_LEAD   = 8'hFD;

    // code lengths
    localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
    localparam logic [LEN_W-1:0] LEN_SHORT = 2'd2;
    localparam logic [LEN_W-1:0] LEN_LONG  = 2'd3;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    // input item
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] word_index;
        logic [BYTE_W-1:0]  first_byte;
        logic [BYTE_W-1:0]  second_byte;
        logic [BYTE_W-1:0]  third_byte;
    } t_in;

    // after the first stage: quotient estimate and code checks
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] idx;
        logic [Q_W-1:0]     q_est;
        logic               enc_bad;
        logic               enc_short;
        logic               dec_long;
        logic               dec_bad;
        logic [4:0]         lead_q;
        logic [1:0]         top;
        logic [BYTE_W-1:0]  dm1;
        logic [BYTE_W-1:0]  dl1;
    } t_sa;

    // after the second stage: exact base-255 split and partial indexes
    typedef struct packed {
        t_op                    op;
        logic                   enc_bad;
        logic                   enc_short;
        logic                   dec_long;
        logic                   dec_bad;
        logic [Q_W-1:0]         q;
        logic [BYTE_W-1:0]      r;
        logic [1:0]             top;
        logic [LO_W-1:0]        dec_lo;
        logic [SHORT_IDX_W-1:0] dec_short_idx;
    } t_sb;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0]  code_lead;
        logic [BYTE_W-1:0]  code_mid;
        logic [BYTE_W-1:0]  code_tail;
        logic [LEN_W-1:0]   code_length;
        logic [INDEX_W-1:0] decoded_index;
        logic               invalid;
    } t_out;

    // index offset of a three-byte code from its lead byte
    function automatic logic [INDEX_W-1:0] long_base(input logic [1:0] top);
        logic [INDEX_W-1:0] base;
        unique case (top)
            2'd0:    base = 18'd0;
            2'd1:    base = 18'd65025;
            2'd2:    base = 18'd130050;
            default: base = INDEX_LIMIT;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/wicc_in_if.sv
// input channel of the codec: handshake plus request fields
interface wicc_in_if;
    import wicc_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [INDEX_W-1:0] word_index;
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  second_byte;
    logic [BYTE_W-1:0]  third_byte;

    modport source (
        output valid, op, word_index, first_byte, second_byte, third_byte,
        input  ready
    );

    modport sink (
        input  valid, op, word_index, first_byte, second_byte, third_byte,
        output ready
    );
endinterface

>>> rtl/wicc_out_if.sv
// output channel of the codec: handshake plus result fields
interface wicc_out_if;
    import wicc_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  code_lead;
    logic [BYTE_W-1:0]  code_mid;
    logic [BYTE_W-1:0]  code_tail;
    logic [LEN_W-1:0]   code_length;
    logic [INDEX_W-1:0] decoded_index;
    logic               invalid;

    modport source (
        output valid, code_lead, code_mid, code_tail, code_length, decoded_index,
               invalid,
        input  ready
    );

    modport sink (
        input  valid, code_lead, code_mid, code_tail, code_length, decoded_index,
               invalid,
        output ready
    );
endinterface

>>> rtl/wicc_split.sv
// first stage: quotient estimate by 255, range and code format checks
module wicc_split (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  wicc_pkg::t_in i_data,
    output logic         o_ready,
    input  logic         i_ready,
    output logic         o_valid,
    output wicc_pkg::t_sa o_data
);
    import wicc_pkg::*;

    logic                 r_valid;
    t_sa                  r_data;
    t_sa                  n_data;
    logic [INDEX_W+7:0]   w_scaled;
    logic                 w_short_fmt;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // x * 257 / 65536 is x / 255 or one short of it
    assign w_scaled = {i_data.word_index, 8'b0} + {8'b0, i_data.word_index};

    // two-byte lead: 0x80..0xBC with low bits clear
    assign w_short_fmt = i_data.first_byte[7]
                      && (i_data.first_byte <= SHORT_LEAD_MAX)
                      && (i_data.first_byte[1:0] == 2'b00);

    always_comb begin
        n_data.op        = i_data.op;
        n_data.idx       = i_data.word_index;
        n_data.q_est     = w_scaled[INDEX_W+7:16];
        n_data.enc_bad   = (i_data.word_index >= INDEX_LIMIT);
        n_data.enc_short = (i_data.word_index < SHORT_LIMIT);
        n_data.dec_long  = (i_data.first_byte >= LONG_LEAD);
        n_data.lead_q    = i_data.first_byte[6:2];
        n_data.top       = 2'(i_data.first_byte - LONG_LEAD);
        n_data.dm1       = i_data.second_byte - 8'd1;
        n_data.dl1       = i_data.third_byte - 8'd1;
        if (n_data.dec_long) begin
            n_data.dec_bad = (i_data.second_byte == '0) || (i_data.third_byte == '0);
        end else begin
            n_data.dec_bad = !(w_short_fmt && (i_data.second_byte != '0));
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

>>> rtl/wicc_digit.sv
// second stage: exact quotient and remainder by 255, partial decoded indexes
module wicc_digit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  wicc_pkg::t_sa i_data,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output wicc_pkg::t_sb o_data
);
    import wicc_pkg::*;

    logic            r_valid;
    t_sb             r_data;
    t_sb             n_data;
    logic [INDEX_W:0] w_rem;
    logic [8:0]      w_rem_lo;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // remainder of the estimate stays below twice the radix
    assign w_rem = (INDEX_W+1)'(i_data.idx) + (INDEX_W+1)'(i_data.q_est)
                 - (INDEX_W+1)'({i_data.q_est, 8'b0});
    assign w_rem_lo = w_rem[8:0];

    always_comb begin
        n_data.op        = i_data.op;
        n_data.enc_bad   = i_data.enc_bad;
        n_data.enc_short = i_data.enc_short;
        n_data.dec_long  = i_data.dec_long;
        n_data.dec_bad   = i_data.dec_bad;
        n_data.top       = i_data.top;
        if (w_rem_lo >= RADIX_REM) begin
            n_data.q = i_data.q_est + 10'd1;
            n_data.r = 8'(w_rem_lo - RADIX_REM);
        end else begin
            n_data.q = i_data.q_est;
            n_data.r = w_rem_lo[7:0];
        end
        // (b1-1)*255 + (b2-1)
        n_data.dec_lo = LO_W'({i_data.dm1, 8'b0}) - LO_W'(i_data.dm1)
                      + LO_W'(i_data.dl1);
        // (lead/4 & 31)*255 + (b1-1)
        n_data.dec_short_idx = SHORT_IDX_W'({i_data.lead_q, 8'b0})
                             - SHORT_IDX_W'(i_data.lead_q)
                             + SHORT_IDX_W'(i_data.dm1);
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

>>> rtl/wicc_pack.sv
// third stage: high digit, full decoded index and the output register
module wicc_pack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wicc_pkg::t_sb  i_data,
    output logic           o_ready,
    input  logic           i_ready,
    output logic           o_valid,
    output wicc_pkg::t_out o_data
);
    import wicc_pkg::*;

    logic               r_valid;
    t_out               r_data;
    t_out               n_data;
    logic [1:0]         w_hi;
    logic [Q_W-1:0]     w_d1;
    logic [INDEX_W-1:0] w_long_idx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // quotient of an in-range index is at most 764, so the high digit is found by compare
    always_comb begin
        priority if (i_data.q >= RADIX_Q2) begin
            w_hi = 2'd2;
        end else if (i_data.q >= RADIX_Q) begin
            w_hi = 2'd1;
        end else begin
            w_hi = 2'd0;
        end
    end

    assign w_d1 = i_data.q - (Q_W'({w_hi, 8'b0}) - Q_W'(w_hi));
    assign w_long_idx = long_base(i_data.top) + INDEX_W'(i_data.dec_lo);

    // result selection
    always_comb begin
        n_data = '0;
        unique case (i_data.op)
            OP_ENCODE: begin
                if (i_data.enc_bad) begin
                    n_data.invalid = 1'b1;
                end else if (i_data.enc_short) begin
                    n_data.code_lead   = SHORT_LEAD + {i_data.q[5:0], 2'b00};
                    n_data.code_mid    = i_data.r + 8'd1;
                    n_data.code_length = LEN_SHORT;
                end else begin
                    n_data.code_lead   = LONG_LEAD + {6'b0, w_hi};
                    n_data.code_mid    = w_d1[7:0] + 8'd1;
                    n_data.code_tail   = i_data.r + 8'd1;
                    n_data.code_length = LEN_LONG;
                end
            end
            OP_DECODE: begin
                if (i_data.dec_bad) begin
                    n_data.invalid = 1'b1;
                end else if (i_data.dec_long) begin
                    // non-canonical three-byte code
                    if (w_long_idx < SHORT_LIMIT) begin
                        n_data.invalid = 1'b1;
                    end else begin
                        n_data.code_length   = LEN_LONG;
                        n_data.decoded_index = w_long_idx;
                    end
                end else begin
                    n_data.code_length   = LEN_SHORT;
                    n_data.decoded_index = INDEX_W'(i_data.dec_short_idx);
                end
            end
            default: n_data.invalid = 1'b1;
        endcase
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

>>> rtl/word_index_code_codec_core.sv
// top level of the word index code codec: three-stage pipeline
// Takes one encode or decode request per cycle while o_out.ready is high, and
// returns one result per request, in order. The work runs through
// three register stages (quotient estimate and checks, exact base-255 split,
// digit and index assembly); the last stage is the output register. Each
// stage loads when it is empty or its successor takes its item, so a stalled
// output holds its result while the stages behind it still fill; ready on the
// input follows combinationally from the stage valids and o_out.ready.
// An invalid result carries zero in every other field.
module word_index_code_codec_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wicc_in_if.sink    i_in,
    wicc_out_if.source o_out
);
    import wicc_pkg::*;

    t_in  w_in;
    t_sa  w_sa;
    t_sb  w_sb;
    t_out w_out;
    logic w_sa_valid;
    logic w_sa_ready;
    logic w_sb_valid;
    logic w_sb_ready;

    // input fields into the request struct
    always_comb begin
        w_in.op          = t_op'(i_in.op);
        w_in.word_index  = i_in.word_index;
        w_in.first_byte  = i_in.first_byte;
        w_in.second_byte = i_in.second_byte;
        w_in.third_byte  = i_in.third_byte;
    end

    wicc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_data  (w_in),
        .o_ready (i_in.ready),
        .i_ready (w_sa_ready),
        .o_valid (w_sa_valid),
        .o_data  (w_sa)
    );

    wicc_digit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sa_valid),
        .i_data  (w_sa),
        .o_ready (w_sa_ready),
        .i_ready (w_sb_ready),
        .o_valid (w_sb_valid),
        .o_data  (w_sb)
    );

    wicc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sb_valid),
        .i_data  (w_sb),
        .o_ready (w_sb_ready),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (w_out)
    );

    // result fields onto the output channel
    assign o_out.code_lead     = w_out.code_lead;
    assign o_out.code_mid      = w_out.code_mid;
    assign o_out.code_tail     = w_out.code_tail;
    assign o_out.code_length   = w_out.code_length;
    assign o_out.decoded_index = w_out.decoded_index;
    assign o_out.invalid       = w_out.invalid;

    // an invalid item carries nothing else
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.invalid) |->
            (o_out.code_length == LEN_NONE) && (o_out.decoded_index == '0)
            && (o_out.code_lead == '0) && (o_out.code_mid == '0)
            && (o_out.code_tail == '0))
        else $error("invalid item with nonzero fields");

    // a good item has a real length and an index in range
    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.invalid) |->
            ((o_out.code_length == LEN_SHORT) || (o_out.code_length == LEN_LONG))
            && (o_out.decoded_index < INDEX_LIMIT))
        else $error("good item with bad length or index");

    // encoded lead bytes only in the two lead ranges, length to match
    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.code_lead != '0)) |->
            ((o_out.code_length == LEN_SHORT) && o_out.code_lead[7]
                && (o_out.code_lead <= SHORT_LEAD_MAX)
                && (o_out.code_lead[1:0] == 2'b00) && (o_out.code_tail == '0))
            || ((o_out.code_length == LEN_LONG) && (o_out.code_lead >= LONG_LEAD)
                && (o_out.code_tail != '0)))
        else $error("encoded lead byte out of range");
endmodule

>>> tb/word_index_code_codec_core_tb.sv
// self-checking testbench of the word index code codec with random handshake idling
module word_index_code_codec_core_tb;
    import wicc_pkg::*;

    localparam int RADIX        = 255;
    localparam int RADIX_SQ     = 65025;
    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;

    wicc_in_if  in_ch ();
    wicc_out_if out_ch ();

    word_index_code_codec_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in  pending_reqs[$];
    t_out expected_codes[$];
    t_in  held_req;
    logic in_busy;
    int   send_gap       = 0;
    int   stall_left     = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    // bit-exact conversion of one request into its result
    function automatic t_out predict_code(input t_in req);
        t_out res;
        int   idx;
        int   b0;
        int   b1;
        int   b2;
        int   rest;
        res = '0;
        if (req.op == OP_ENCODE) begin
            idx = int'(req.word_index);
            if (idx >= INDEX_LIMIT) begin
                res.invalid = 1'b1;
            end else if (idx < SHORT_LIMIT) begin
                res.code_lead   = BYTE_W'(SHORT_LEAD + ((idx / RADIX) << 2));
                res.code_mid    = BYTE_W'((idx % RADIX) + 1);
                res.code_length = LEN_SHORT;
            end else begin
                rest            = idx % RADIX_SQ;
                res.code_lead   = BYTE_W'(LONG_LEAD + (idx / RADIX_SQ));
                res.code_mid    = BYTE_W'((rest / RADIX) + 1);
                res.code_tail   = BYTE_W'((rest % RADIX) + 1);
                res.code_length = LEN_LONG;
            end
        end else begin
            b0 = int'(req.first_byte);
            b1 = int'(req.second_byte);
            b2 = int'(req.third_byte);
            if (b0 >= LONG_LEAD) begin
                // three-byte code: zero digits and short indexes are malformed
                idx = (b0 - LONG_LEAD) * RADIX_SQ + (b1 - 1) * RADIX + (b2 - 1);
                if (b1 == 0 || b2 == 0 || idx < SHORT_LIMIT) begin
                    res.invalid = 1'b1;
                end else begin
                    res.code_length   = LEN_LONG;
                    res.decoded_index = INDEX_W'(idx);
                end
            end else if (b0 >= SHORT_LEAD && b0 <= SHORT_LEAD_MAX && b0 % 4 == 0 && b1 != 0) begin
                res.code_length   = LEN_SHORT;
                res.decoded_index = INDEX_W'(((b0 - SHORT_LEAD) >> 2) * RADIX + (b1 - 1));
            end else begin
                res.invalid = 1'b1;
            end
        end
        return res;
    endfunction

    // request with every field random
    function automatic t_in noise_request();
        t_in req;
        req.op          = $urandom_range(0, 1) ? OP_DECODE : OP_ENCODE;
        req.word_index  = INDEX_W'($urandom_range(0, 262143));
        req.first_byte  = BYTE_W'($urandom_range(0, 255));
        req.second_byte = BYTE_W'($urandom_range(0, 255));
        req.third_byte  = BYTE_W'($urandom_range(0, 255));
        return req;
    endfunction

    // random request, mostly well-formed codes and in-range indexes
    function automatic t_in random_request();
        t_in  req;
        t_in  enc;
        t_out code;
        int   kind;
        req  = noise_request();
        kind = int'($urandom_range(0, 9));
        if (kind <= 4) begin
            req.op = OP_ENCODE;
            if (kind <= 2) req.word_index = INDEX_W'($urandom_range(0, 195074));
            else if (kind == 3) req.word_index = INDEX_W'($urandom_range(0, 4079));
        end else if (kind <= 7) begin
            // round trip: decode the code of a random valid index
            enc = req;
            enc.op = OP_ENCODE;
            enc.word_index = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 4079))
                                                  : INDEX_W'($urandom_range(0, 195074));
            code = predict_code(enc);
            req.op          = OP_DECODE;
            req.first_byte  = code.code_lead;
            req.second_byte = code.code_mid;
            if (code.code_length == LEN_LONG) req.third_byte = code.code_tail;
        end else if (kind == 8) begin
            // plausible lead, random digit bytes
            req.op = OP_DECODE;
            req.first_byte = $urandom_range(0, 1)
                           ? BYTE_W'($urandom_range(253, 255))
                           : BYTE_W'(SHORT_LEAD + 4 * $urandom_range(0, 15));
        end
        return req;
    endfunction

    task automatic add_encode(input int idx);
        t_in req;
        req = '0;
        req.op = OP_ENCODE;
        req.word_index = INDEX_W'(idx);
        pending_reqs.push_back(req);
    endtask

    task automatic add_decode(input int b0, input int b1, input int b2);
        t_in req;
        req = '0;
        req.op = OP_DECODE;
        req.first_byte  = BYTE_W'(b0);
        req.second_byte = BYTE_W'(b1);
        req.third_byte  = BYTE_W'(b2);
        pending_reqs.push_back(req);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // request driver with random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.op          <= 1'b0;
            in_ch.word_index  <= '0;
            in_ch.first_byte  <= '0;
            in_ch.second_byte <= '0;
            in_ch.third_byte  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_codes.push_back(predict_code(held_req));
                in_busy = 1'b0;
            end else begin
                in_busy = in_ch.valid;
            end
            if (!in_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
                    send_gap = int'($urandom_range(0, 7));
                    in_ch.valid <= 1'b0;
                end else begin
                    held_req = pending_reqs.pop_front();
                    in_ch.op          <= held_req.op;
                    in_ch.word_index  <= held_req.word_index;
                    in_ch.first_byte  <= held_req.first_byte;
                    in_ch.second_byte <= held_req.second_byte;
                    in_ch.third_byte  <= held_req.third_byte;
                    in_ch.valid       <= 1'b1;
                end
            end
        end
    end

    // result checker with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual lead %0d index %0d",
                             $time, out_ch.code_lead, out_ch.decoded_index);
                    mismatch_count++;
                end else begin
                    report_field("code_lead", int'(expected_codes[0].code_lead),
                                 int'(out_ch.code_lead));
                    report_field("code_mid", int'(expected_codes[0].code_mid),
                                 int'(out_ch.code_mid));
                    report_field("code_tail", int'(expected_codes[0].code_tail),
                                 int'(out_ch.code_tail));
                    report_field("code_length", int'(expected_codes[0].code_length),
                                 int'(out_ch.code_length));
                    report_field("decoded_index", int'(expected_codes[0].decoded_index),
                                 int'(out_ch.decoded_index));
                    report_field("invalid", int'(expected_codes[0].invalid),
                                 int'(out_ch.invalid));
                    void'(expected_codes.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (pending_reqs.size() > CALM_ITEMS && $urandom_range(0, 4) == 0) begin
                stall_left = int'($urandom_range(0, 7));
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n = 1'b0;

        // encode: range ends, short/long boundary, lead steps, too large
        add_encode(0);
        add_encode(254);
        add_encode(255);
        add_encode(4079);
        add_encode(4080);
        add_encode(65025);
        add_encode(130050);
        add_encode(195074);
        add_encode(195075);
        add_encode(262143);
        // decode: good short and long codes
        add_decode(8'h80, 1, 0);
        add_decode(8'hBC, 255, 255);
        add_decode(8'hFD, 17, 1);
        add_decode(8'hFF, 255, 255);
        // bad two-byte leads
        add_decode(8'h7F, 5, 5);
        add_decode(8'h81, 5, 5);
        add_decode(8'hBD, 5, 5);
        add_decode(8'hFC, 5, 5);
        add_decode(8'h00, 1, 1);
        // zero digit bytes
        add_decode(8'h80, 0, 7);
        add_decode(8'hFE, 0, 9);
        add_decode(8'hFE, 9, 0);
        // non-canonical three-byte codes
        add_decode(8'hFD, 1, 1);
        add_decode(8'hFD, 16, 255);

        repeat (RANDOM_ITEMS) pending_reqs.push_back(random_request());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wicc_pkg.sv
rtl/wicc_in_if.sv
rtl/wicc_out_if.sv
rtl/wicc_split.sv
rtl/wicc_digit.sv
rtl/wicc_pack.sv
rtl/word_index_code_codec_core.sv
tb/word_index_code_codec_core_tb.sv
